// ===== design/cdd_pkg.sv =====
// Shared types, constants and calendar helpers for the calendar date difference core.
// Used by cdd_seq, cdd_walker and calendar_date_difference_core.
`timescale 1ns / 1ps

package cdd_pkg;

   localparam int DAY_W   = 5;
   localparam int MON_W   = 4;
   localparam int YEAR_W  = 14;
   localparam int CNT_W   = 22;
   localparam int IDX_W   = 4;

   localparam int REQ_BITS   = 2 * (DAY_W + MON_W + YEAR_W) + 1;
   localparam int REQ_DATA_W = ((REQ_BITS + 7) / 8) * 8;
   localparam int RSP_DATA_W = ((CNT_W + 7) / 8) * 8;

   localparam logic [CNT_W-1:0]  COUNT_MAX  = {CNT_W{1'b1}};
   // year mod 25 together with year mod 4 / mod 16 gives the 100 and 400 rules
   localparam logic [YEAR_W-1:0] MOD_BASE   = YEAR_W'(25);
   localparam logic [4:0]        MOD_LAST   = 5'd24;
   localparam logic [IDX_W-1:0]  REDUCE_TOP = IDX_W'(9);
   localparam logic [MON_W-1:0]  DECEMBER   = MON_W'(12);
   localparam logic [MON_W-1:0]  FEBRUARY   = MON_W'(2);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_REDUCE,
      ST_CHECK,
      ST_WALK,
      ST_FINISH
   } state_type;

   // request fields, start_day in the lowest bits and include_end in the highest
   typedef struct packed {
      logic              include_end;
      logic [YEAR_W-1:0] end_year;
      logic [MON_W-1:0]  end_month;
      logic [DAY_W-1:0]  end_day;
      logic [YEAR_W-1:0] start_year;
      logic [MON_W-1:0]  start_month;
      logic [DAY_W-1:0]  start_day;
   } req_type;

   // sequencer to walker
   typedef struct packed {
      logic             load;
      logic             reduce;
      logic [IDX_W-1:0] shift_idx;
      logic             check;
      logic             step;
      logic             finish;
   } ctrl_type;

   // walker to sequencer
   typedef struct packed {
      logic start_ok;
      logic more;
   } stat_type;

   function automatic logic is_leap(input logic [3:0] year_low, input logic [4:0] rem25);
      logic z25;
      z25 = (rem25 == 5'd0);
      return ((year_low[1:0] == 2'd0) && !z25) || ((year_low == 4'd0) && z25);
   endfunction

   function automatic logic [DAY_W-1:0] month_days(input logic [MON_W-1:0] mon,
                                                  input logic leap);
      logic [DAY_W-1:0] len;
      unique case (mon)
         4'd2:                   len = leap ? 5'd29 : 5'd28;
         4'd4, 4'd6, 4'd9, 4'd11: len = 5'd30;
         default:                len = 5'd31;
      endcase
      return len;
   endfunction

endpackage

// ===== design/calendar_date_difference_core.sv =====
// Top level of the calendar date difference core: stream ports and result register.
// Depends on cdd_pkg, cdd_seq and cdd_walker.
`timescale 1ns / 1ps
//
// Usage
//   req_* carries one item with a start date, an end date and include_end.
//   rsp_* returns one item per request: day_count in rsp_tdata, status in rsp_tuser.
//   An item is taken when tvalid and tready are both high at a rising clock edge.
// Timing
//   The start year is reduced mod 25 by restoring steps, the start date is checked, then
//   the walk adds one day per cycle until the start reaches the end bound or the count
//   saturates. The result register loads in the finish state once it is free; an
//   invalid start date goes from the check straight to the finish state.
//   req_tready is high only while no item is in work.
// Reset
//   reset (synchronous, active high) returns the sequencer to idle and drops rsp_tvalid.
// Stall
//   A finished result waits in the output register; a new item may be taken
//   meanwhile, and its result is held in the walker until the register is free.
//
module calendar_date_difference_core (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_tvalid,
   output logic                            req_tready,
   // start_day, start_month, start_year, end_day, end_month, end_year, include_end
   input  logic [cdd_pkg::REQ_DATA_W-1:0]  req_tdata,
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   // day_count
   output logic [cdd_pkg::RSP_DATA_W-1:0]  rsp_tdata,
   // status
   output logic                            rsp_tuser
);
   import cdd_pkg::*;

   req_type          req;
   ctrl_type         ctrl;
   stat_type         stat;
   logic [CNT_W-1:0] res_count;
   logic             res_status;
   logic             out_free;

   logic             rsp_valid_ff, rsp_valid_in;
   logic [CNT_W-1:0] rsp_count_ff;
   logic             rsp_status_ff;

   assign req      = req_type'(req_tdata[REQ_BITS-1:0]);
   assign out_free = !rsp_valid_ff || rsp_tready;

   cdd_seq u_seq (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_tvalid),
      .req_ready (req_tready),
      .out_free  (out_free),
      .stat      (stat),
      .ctrl      (ctrl)
   );

   cdd_walker u_walker (
      .clock      (clock),
      .req        (req),
      .ctrl       (ctrl),
      .stat       (stat),
      .res_count  (res_count),
      .res_status (res_status)
   );

   // output register
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (ctrl.finish) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.finish) begin
         rsp_count_ff  <= res_count;
         rsp_status_ff <= res_status;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = RSP_DATA_W'(rsp_count_ff);
   assign rsp_tuser  = rsp_status_ff;

endmodule

// ===== design/cdd_seq.sv =====
// Sequencer for the calendar date difference core: reduce, check, walk, finish.
// Depends on cdd_pkg.
`timescale 1ns / 1ps

module cdd_seq (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  logic              out_free,
   input  cdd_pkg::stat_type stat,
   output cdd_pkg::ctrl_type ctrl
);
   import cdd_pkg::*;

   state_type        state_ff, state_in;
   logic [IDX_W-1:0] idx_ff, idx_in;

   // state and shift index registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         idx_ff   <= '0;
      end else begin
         state_ff <= state_in;
         idx_ff   <= idx_in;
      end
   end

   // next state and controls
   always_comb begin
      state_in       = state_ff;
      idx_in         = idx_ff;
      req_ready      = 1'b0;
      ctrl           = '0;
      ctrl.shift_idx = idx_ff;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               ctrl.load = 1'b1;
               idx_in    = REDUCE_TOP;
               state_in  = ST_REDUCE;
            end
         end
         ST_REDUCE: begin
            ctrl.reduce = 1'b1;
            if (idx_ff == '0) begin
               state_in = ST_CHECK;
            end else begin
               idx_in = idx_ff - 1'b1;
            end
         end
         ST_CHECK: begin
            ctrl.check = 1'b1;
            state_in   = stat.start_ok ? ST_WALK : ST_FINISH;
         end
         ST_WALK: begin
            if (stat.more) begin
               ctrl.step = 1'b1;
            end else begin
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            if (out_free) begin
               ctrl.finish = 1'b1;
               state_in    = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

endmodule

// ===== design/cdd_walker.sv =====
// Date registers and the shared step unit: mod-25 reduction, start check,
// one-day date increment and the end compare. Depends on cdd_pkg.
`timescale 1ns / 1ps

module cdd_walker (
   input  logic                     clock,
   input  cdd_pkg::req_type         req,
   input  cdd_pkg::ctrl_type        ctrl,
   output cdd_pkg::stat_type        stat,
   output logic [cdd_pkg::CNT_W-1:0] res_count,
   output logic                     res_status
);
   import cdd_pkg::*;

   logic [DAY_W-1:0]  day_ff, day_in;
   logic [MON_W-1:0]  month_ff, month_in;
   logic [YEAR_W:0]   year_ff, year_in;       // one extra bit so the walk can pass the top year
   logic [YEAR_W-1:0] rem_ff, rem_in;
   logic [DAY_W-1:0]  end_day_ff;
   logic [MON_W-1:0]  end_month_ff;
   logic [YEAR_W-1:0] end_year_ff;
   logic              inc_ff;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic              bad_ff, bad_in;

   logic              leap;
   logic [DAY_W-1:0]  len;
   logic [YEAR_W-1:0] sub;
   logic              earlier;

   // calendar of the current date
   assign leap = is_leap(year_ff[3:0], rem_ff[4:0]);
   assign len  = month_days(month_ff, leap);
   assign sub  = MOD_BASE << ctrl.shift_idx;

   // current date strictly before the end bound
   always_comb begin
      earlier = 1'b0;
      if (year_ff != {1'b0, end_year_ff}) begin
         earlier = year_ff < {1'b0, end_year_ff};
      end else if (month_ff != end_month_ff) begin
         earlier = month_ff < end_month_ff;
      end else begin
         earlier = day_ff < end_day_ff;
      end
   end

   assign stat.start_ok = (day_ff != '0) && (month_ff != '0) && (month_ff <= DECEMBER)
                          && (day_ff <= len);
   assign stat.more     = earlier && (count_ff != COUNT_MAX);

   // next values of the working registers
   always_comb begin
      day_in   = day_ff;
      month_in = month_ff;
      year_in  = year_ff;
      rem_in   = rem_ff;
      count_in = count_ff;
      bad_in   = bad_ff;
      priority if (ctrl.load) begin
         day_in   = req.start_day;
         month_in = req.start_month;
         year_in  = {1'b0, req.start_year};
         rem_in   = req.start_year;
         count_in = '0;
         bad_in   = 1'b0;
      end else if (ctrl.reduce) begin
         // one restoring step of year mod 25
         if (rem_ff >= sub) begin
            rem_in = rem_ff - sub;
         end
      end else if (ctrl.check) begin
         bad_in = !stat.start_ok;
      end else if (ctrl.step) begin
         count_in = count_ff + 1'b1;
         if (day_ff < len) begin
            day_in = day_ff + 1'b1;
         end else begin
            day_in = DAY_W'(1);
            if (month_ff == DECEMBER) begin
               month_in = MON_W'(1);
               year_in  = year_ff + 1'b1;
               rem_in   = (rem_ff[4:0] == MOD_LAST) ? '0 : rem_ff + 1'b1;
            end else begin
               month_in = month_ff + 1'b1;
            end
         end
      end
   end

   // working and bound registers
   always_ff @(posedge clock) begin
      day_ff   <= day_in;
      month_ff <= month_in;
      year_ff  <= year_in;
      rem_ff   <= rem_in;
      count_ff <= count_in;
      bad_ff   <= bad_in;
      if (ctrl.load) begin
         end_day_ff   <= req.end_day;
         end_month_ff <= req.end_month;
         end_year_ff  <= req.end_year;
         inc_ff       <= req.include_end;
      end
   end

   // final count with the end day added, saturating; zero for an invalid start
   always_comb begin
      priority if (bad_ff) begin
         res_count = '0;
      end else if (count_ff == COUNT_MAX) begin
         res_count = COUNT_MAX;
      end else begin
         res_count = count_ff + CNT_W'(inc_ff);
      end
   end
   assign res_status = bad_ff;

   // a walk step only ever sees a valid date
   a_step_valid: assert property (@(posedge clock)
      ctrl.step |-> (day_ff != '0 && month_ff != '0 && month_ff <= DECEMBER))
      else $error("walk step on an invalid date");

   // reduction leaves the residue below 25 by the check
   a_rem_reduced: assert property (@(posedge clock)
      ctrl.check |-> (rem_ff < MOD_BASE))
      else $error("year residue not reduced");

   // every step adds exactly one day
   a_step_count: assert property (@(posedge clock)
      ctrl.step |=> (count_ff == CNT_W'($past(count_ff) + 1'b1)))
      else $error("day count did not advance by one");

   // an invalid start always reports a zero count
   a_bad_zero: assert property (@(posedge clock)
      (ctrl.finish && bad_ff) |-> (res_count == '0 && res_status))
      else $error("invalid start with nonzero count");

endmodule

// ===== dv/tb_calendar_date_difference_core.sv =====
`timescale 1ns / 1ps
// Testbench for calendar_date_difference_core: directed and random date pairs go through
// the request stream, and each day count and status is checked against a local calendar model.
// Depends on cdd_pkg and the core RTL.

module tb_calendar_date_difference_core;

   localparam int          CNT_W         = cdd_pkg::CNT_W;
   localparam int unsigned COUNT_SAT     = (1 << cdd_pkg::CNT_W) - 1;
   localparam int          RANDOM_ITEMS  = 136;
   localparam int          SETTLE_CYCLES = 100;
   // worst gap, stall and fixed latency per item, in cycles
   localparam int          ITEM_SLACK    = 600;

   // one queued request and whether it waits for all results first
   typedef struct {
      cdd_pkg::req_type dates;
      bit               drain_first;
   } stim_type;

   // one predicted result
   typedef struct {
      logic [CNT_W-1:0] day_count;
      logic             status;
   } span_type;

   logic                              clock;
   logic                              reset      = 1'b1;
   logic                              req_tvalid = 1'b0;
   logic                              req_tready;
   logic [cdd_pkg::REQ_DATA_W-1:0]    req_tdata  = '0;
   logic                              rsp_tvalid;
   logic                              rsp_tready = 1'b0;
   logic [cdd_pkg::RSP_DATA_W-1:0]    rsp_tdata;
   logic                              rsp_tuser;

   stim_type    date_pairs[$];
   span_type    spans_due[$];
   span_type    want;
   int          mismatch_count = 0;
   longint      cycle_count    = 0;
   longint      cycle_limit    = 64'd1 << 40;
   longint      cycle_budget   = 0;
   bit          req_fire;
   int unsigned gap_left   = 0;
   int unsigned burst_left = 0;
   int unsigned ready_run  = 0;
   int unsigned stall_run  = 0;

   calendar_date_difference_core uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   // ---------------- calendar model ----------------

   function automatic bit leap_yr(input int unsigned y);
      return ((y % 4 == 0) && (y % 100 != 0)) || (y % 400 == 0);
   endfunction

   function automatic int unsigned month_length(input int unsigned y, input int unsigned m);
      case (m)
         2:           return leap_yr(y) ? 29 : 28;
         4, 6, 9, 11: return 30;
         default:     return 31;
      endcase
   endfunction

   // days in years 0 .. y-1, year 0 counted as leap
   function automatic int unsigned days_to_year(input int unsigned y);
      int unsigned p;
      if (y == 0) return 0;
      p = y - 1;
      return y * 365 + p / 4 - p / 100 + p / 400 + 1;
   endfunction

   // valid dates strictly before (y, m, d); out-of-range month or day acts as a bound
   function automatic int unsigned date_ordinal(input int unsigned y, input int unsigned m,
                                                input int unsigned d);
      int unsigned n;
      int unsigned full;
      int unsigned len;
      n    = days_to_year(y);
      full = (m == 0) ? 0 : ((m > 12) ? 12 : m - 1);
      for (int unsigned k = 1; k <= full; k++) n += month_length(y, k);
      if (m >= 1 && m <= 12 && d >= 1) begin
         len = month_length(y, m);
         n += (d - 1 < len) ? d - 1 : len;
      end
      return n;
   endfunction

   function automatic span_type predict_span(input cdd_pkg::req_type r);
      span_type    res;
      int unsigned cnt;
      bit          ahead;
      res.status    = 1'b0;
      res.day_count = '0;
      cnt           = 0;
      // bad start date gives status 1 and a zero count
      if (r.start_day == 0 || r.start_month == 0 || r.start_month > 12 ||
          r.start_day > month_length(r.start_year, r.start_month)) begin
         res.status = 1'b1;
         return res;
      end
      ahead = (r.start_year < r.end_year) ||
              (r.start_year == r.end_year && (r.start_month < r.end_month ||
              (r.start_month == r.end_month && r.start_day < r.end_day)));
      if (ahead)
         cnt = date_ordinal(r.end_year, r.end_month, r.end_day) -
               date_ordinal(r.start_year, r.start_month, r.start_day);
      cnt += r.include_end;
      if (cnt > COUNT_SAT) cnt = COUNT_SAT;
      res.day_count = cnt[CNT_W-1:0];
      return res;
   endfunction

   // ---------------- stimulus ----------------

   task automatic add_item(input int unsigned sd, input int unsigned sm, input int unsigned sy,
                           input int unsigned ed, input int unsigned em, input int unsigned ey,
                           input int unsigned inc, input bit drain);
      stim_type s;
      span_type span_now;
      s.dates.start_day   = cdd_pkg::DAY_W'(sd);
      s.dates.start_month = cdd_pkg::MON_W'(sm);
      s.dates.start_year  = cdd_pkg::YEAR_W'(sy);
      s.dates.end_day     = cdd_pkg::DAY_W'(ed);
      s.dates.end_month   = cdd_pkg::MON_W'(em);
      s.dates.end_year    = cdd_pkg::YEAR_W'(ey);
      s.dates.include_end = inc[0];
      s.drain_first       = drain;
      date_pairs.push_back(s);
      span_now      = predict_span(s.dates);
      cycle_budget += span_now.day_count + ITEM_SLACK;
   endtask

   function automatic int unsigned pick_day(input int unsigned y, input int unsigned m);
      return $urandom_range(1, month_length(y, m));
   endfunction

   task automatic fill_random();
      int unsigned kind;
      int unsigned sd, sm, sy, ed, em, ey;
      for (int i = 0; i < RANDOM_ITEMS; i++) begin
         kind = $urandom_range(0, 99);
         sy   = $urandom_range(0, 16383);
         sm   = $urandom_range(1, 12);
         sd   = pick_day(sy, sm);
         ey   = sy;
         em   = sm;
         ed   = sd;
         if (kind < 35) begin
            // end in the same year, in the same month or later
            em = $urandom_range(sm, 12);
            ed = pick_day(ey, em);
         end else if (kind < 65) begin
            // across a year end, unless the start is in the top year
            ey = (sy < 16383) ? sy + 1 : sy;
            em = $urandom_range(1, 12);
            ed = pick_day(ey, em);
         end else if (kind < 75) begin
            // end year and month not after the start
            ey = $urandom_range(0, sy);
            em = (ey == sy) ? $urandom_range(1, sm) : $urandom_range(1, 12);
            ed = pick_day(ey, em);
         end else if (kind < 85) begin
            // bad start date, end anywhere
            sd = $urandom_range(0, 31);
            sm = $urandom_range(0, 15);
            if (sm >= 1 && sm <= 12 && sd >= 1 && sd <= month_length(sy, sm))
               sm = $urandom_range(0, 1) ? 0 : $urandom_range(13, 15);
            ey = $urandom_range(0, 16383);
            em = $urandom_range(0, 15);
            ed = $urandom_range(0, 31);
         end else if (kind < 95) begin
            // end date fields that may be out of range, used only as a bound
            ey = (sy < 16383) ? sy + $urandom_range(0, 1) : sy;
            em = $urandom_range(0, 15);
            ed = $urandom_range(0, 31);
         end else begin
            // span of a few years
            ey = sy + $urandom_range(2, 12);
            if (ey > 16383) ey = 16383;
            em = $urandom_range(1, 12);
            ed = pick_day(ey, em);
         end
         add_item(sd, sm, sy, ed, em, ey, $urandom_range(0, 1), $urandom_range(0, 19) == 0);
      end
   endtask

   // ---------------- request driver ----------------

   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else begin
         req_fire = req_tvalid && req_tready;
         if (req_fire) begin
            spans_due.push_back(predict_span(date_pairs[0].dates));
            void'(date_pairs.pop_front());
         end
         if (!req_tvalid || req_fire) begin
            if (gap_left > 0) begin
               gap_left--;
               req_tvalid <= 1'b0;
            end else if (date_pairs.size() == 0) begin
               req_tvalid <= 1'b0;
            end else if (date_pairs[0].drain_first && spans_due.size() != 0) begin
               req_tvalid <= 1'b0;
            end else begin
               req_tvalid <= 1'b1;
               req_tdata  <= cdd_pkg::REQ_DATA_W'(date_pairs[0].dates);
               if (burst_left > 0) begin
                  burst_left--;
               end else begin
                  burst_left = $urandom_range(0, 6);
                  case ($urandom_range(0, 5))
                     0, 1:    gap_left = 0;
                     5:       gap_left = $urandom_range(50, 400);
                     default: gap_left = $urandom_range(1, 20);
                  endcase
               end
            end
         end
      end
   end

   // ---------------- result monitor ----------------

   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (spans_due.size() == 0) begin
               $error("result with none expected: day_count %0d status %0b",
                      rsp_tdata[CNT_W-1:0], rsp_tuser);
               mismatch_count++;
            end else begin
               want = spans_due.pop_front();
               if (rsp_tdata[CNT_W-1:0] !== want.day_count) begin
                  $error("day_count: expected %0d, actual %0d",
                         want.day_count, rsp_tdata[CNT_W-1:0]);
                  mismatch_count++;
               end
               if (rsp_tuser !== want.status) begin
                  $error("status: expected %0b, actual %0b", want.status, rsp_tuser);
                  mismatch_count++;
               end
            end
         end
         // ready runs broken by stalls of random length
         if (stall_run > 0) begin
            stall_run--;
            rsp_tready <= 1'b0;
         end else if (ready_run > 0) begin
            ready_run--;
            rsp_tready <= 1'b1;
         end else begin
            ready_run  = $urandom_range(1, 80);
            stall_run  = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 40);
            rsp_tready <= 1'b1;
         end
      end
   end

   // ---------------- watchdog ----------------

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > cycle_limit) begin
         $display("end of test: mismatches");
         $finish;
      end
   end

   // ---------------- sequence ----------------

   initial begin
      // equal dates, with and without the end day
      add_item(1, 1, 1, 1, 1, 1, 0, 0);
      add_item(1, 1, 1, 1, 1, 1, 1, 0);
      add_item(31, 1, 1999, 31, 1, 1999, 1, 0);
      // year zero is a leap year
      add_item(1, 1, 0, 1, 1, 1, 0, 0);
      // February ends under the leap rules
      add_item(28, 2, 2023, 1, 3, 2023, 0, 0);
      add_item(28, 2, 2024, 1, 3, 2024, 0, 0);
      add_item(28, 2, 1900, 1, 3, 1900, 0, 0);
      add_item(28, 2, 2000, 1, 3, 2000, 1, 0);
      add_item(29, 2, 2000, 5, 3, 2000, 0, 0);
      // bad start dates
      add_item(29, 2, 1900, 1, 3, 1900, 1, 0);
      add_item(0, 6, 2020, 1, 7, 2020, 1, 0);
      add_item(15, 0, 2020, 1, 1, 2021, 0, 0);
      add_item(31, 15, 16383, 31, 15, 16383, 1, 0);
      add_item(31, 4, 2021, 1, 5, 2021, 0, 0);
      // year end and top of the year range
      add_item(31, 12, 9998, 1, 1, 9999, 1, 0);
      add_item(30, 12, 16383, 31, 12, 16383, 1, 0);
      add_item(31, 12, 16382, 31, 12, 16383, 0, 0);
      // start after end
      add_item(10, 6, 2020, 1, 6, 2020, 1, 0);
      add_item(10, 6, 2020, 1, 6, 2020, 0, 1);
      // end date fields out of range
      add_item(15, 12, 2020, 31, 0, 2021, 0, 0);
      add_item(1, 12, 2020, 31, 15, 2020, 1, 0);
      add_item(20, 2, 2020, 0, 3, 2020, 0, 0);
      add_item(25, 4, 2021, 31, 4, 2021, 0, 0);
      // full range saturates the count
      add_item(1, 1, 0, 31, 12, 16383, 1, 1);
      fill_random();
      cycle_limit = 2 * cycle_budget + 50000;

      repeat (8) @(posedge clock);
      reset <= 1'b0;

      while (date_pairs.size() != 0 || req_tvalid || spans_due.size() != 0)
         @(negedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);

      if (mismatch_count == 0)
         $display("end of test: clean");
      else
         $display("end of test: mismatches");
      $finish;
   end

endmodule
